>>> hw/rtl/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
    localparam int HEAP_BYTES  = 4096;
    localparam int MAX_EXTENTS = 64;
    localparam int HDR_BYTES   = 8;

    localparam int DW    = 32;
    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam int HA_W  = $clog2(HEAP_BYTES);
    localparam int REQ_W = 12;
    localparam int OFS_W = 13;
    localparam int LIV_W = 10;
    localparam int ENT_W = 7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [REQ_W-1:0] request_bytes;
        logic [OFS_W-1:0] release_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] granted_offset;
        logic [OFS_W-1:0] free_bytes;
        logic [LIV_W-1:0] live_blocks;
        logic [ENT_W-1:0] free_entries;
    } t_rsp;

    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] len;
    } t_ext;
endpackage
`default_nettype wire

>>> hw/rtl/ffha_ram.sv
`default_nettype none
module ffha_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/first_fit_heap_allocator_top.sv
// channel | dir | handshake                | payload
// request | in  | i_req_valid/o_req_ready  | i_req (t_req)
// result  | out | o_rsp_valid/i_rsp_ready  | o_rsp (t_rsp)
// Alloc: scan one extent per cycle over the RAM read port (S_SCAN); a fit goes to
// S_A_UPD, then S_DN shifts later entries down to drop an emptied entry, then S_DONE.
// Free: header read (S_HDR_RD, S_HDR_WAIT), a full scan, merge (S_F_UPD), then S_UP
// shifts entries for a front insert or S_DN drops a merged right entry, then result.
// Reset: S_INIT writes the initial extent, then the block takes requests.
// A result waiting on i_rsp_ready holds the block in its final step.
`default_nettype none
module first_fit_heap_allocator_top
    import ffha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HDR_RD, S_HDR_WAIT, S_SCAN, S_A_UPD, S_F_UPD, S_DN, S_UP, S_DONE
    } t_state;

    t_state           r_state;
    logic             r_cmd;
    logic [DW-1:0]    r_need, r_h, r_span;
    logic [CNT_W-1:0] r_count, r_rd_cnt;
    logic [DW-1:0]    r_live;
    logic [OFS_W-1:0] r_free, r_granted;
    logic [1:0]       r_status;
    logic             r_dv;
    logic [IDX_W-1:0] r_didx, r_fidx, r_li, r_ri;
    logic [DW-1:0]    r_fst, r_flen, r_lst, r_llen, r_rlen;
    logic             r_hl, r_hr;
    t_rsp             r_rsp;

    logic             issue, found, we, hdr_we, hr_eff;
    logic [IDX_W-1:0] rd_addr, waddr;
    t_ext             wdata, rdata;
    logic [CNT_W-1:0] cnt_m1;
    logic [DW-1:0]    newlen;
    logic [REQ_W-1:0] hdr_rdata;

    ffha_ram #(.W(2*DW), .D(MAX_EXTENTS)) u_ext (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(rd_addr), .o_rdata(rdata)
    );

    ffha_ram #(.W(REQ_W), .D(HEAP_BYTES)) u_hdr (
        .i_clk(i_clk), .i_we(hdr_we), .i_waddr(r_fst[HA_W-1:0]),
        .i_wdata(r_need[REQ_W-1:0] - REQ_W'(HDR_BYTES)),
        .i_raddr(r_h[HA_W-1:0]), .o_rdata(hdr_rdata)
    );

    assign cnt_m1 = r_rd_cnt - 1'b1;
    assign newlen = r_flen - r_need;
    assign hr_eff = r_hr && !(r_hl && r_li == r_ri);
    assign found  = (r_state == S_SCAN) && (r_cmd == CMD_ALLOC) && r_dv && (rdata.len >= r_need);
    assign hdr_we = (r_state == S_A_UPD) && (r_fst < DW'(HEAP_BYTES));

    always_comb begin
        issue   = 1'b0;
        rd_addr = r_rd_cnt[IDX_W-1:0];
        we      = 1'b0;
        waddr   = r_didx;
        wdata   = rdata;
        case (r_state)
            S_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{start: '0, len: DW'(HEAP_BYTES)};
            end
            S_SCAN: begin
                issue = (r_rd_cnt < r_count) && !found;
            end
            S_DN: begin
                issue = r_rd_cnt < r_count;
                we    = r_dv;
                waddr = r_didx - 1'b1;
            end
            S_UP: begin
                issue   = r_rd_cnt != '0;
                rd_addr = cnt_m1[IDX_W-1:0];
                if (r_dv) begin
                    we    = 1'b1;
                    waddr = r_didx + 1'b1;
                end else if (!issue) begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = '{start: r_h, len: r_span};
                end
            end
            S_A_UPD: begin
                we    = newlen != '0;
                waddr = r_fidx;
                wdata = '{start: r_fst + r_need, len: newlen};
            end
            S_F_UPD: begin
                if (r_hl) begin
                    we    = 1'b1;
                    waddr = r_li;
                    wdata = '{start: r_lst,
                              len: r_llen + r_span + (hr_eff ? r_rlen : '0)};
                end else if (r_hr) begin
                    we    = 1'b1;
                    waddr = r_ri;
                    wdata = '{start: r_h, len: r_rlen + r_span};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= CNT_W'(1);
            r_live      <= '0;
            r_free      <= OFS_W'(HEAP_BYTES);
            r_dv        <= 1'b0;
            o_rsp_valid <= 1'b0;
        end else begin
            r_dv   <= issue;
            r_didx <= rd_addr;
            if (r_state == S_DONE && (!o_rsp_valid || i_rsp_ready)) begin
                o_rsp_valid <= 1'b1;
            end else if (o_rsp_valid && i_rsp_ready) begin
                o_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cmd     <= i_req.command;
                        r_need    <= DW'(i_req.request_bytes) + DW'(HDR_BYTES);
                        r_h       <= DW'(i_req.release_offset) - DW'(HDR_BYTES);
                        r_status  <= ST_OK;
                        r_granted <= '0;
                        r_rd_cnt  <= '0;
                        r_hl      <= 1'b0;
                        r_hr      <= 1'b0;
                        if (i_req.command == CMD_ALLOC) begin
                            r_state <= S_SCAN;
                        end else if (i_req.release_offset < OFS_W'(HDR_BYTES) ||
                                     DW'(i_req.release_offset) - DW'(HDR_BYTES)
                                         >= DW'(HEAP_BYTES)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_HDR_RD;
                        end
                    end
                end
                S_HDR_RD: r_state <= S_HDR_WAIT;
                S_HDR_WAIT: begin
                    r_span  <= DW'(hdr_rdata) + DW'(HDR_BYTES);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (issue) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end
                    if (found) begin
                        r_fidx  <= r_didx;
                        r_fst   <= rdata.start;
                        r_flen  <= rdata.len;
                        r_state <= S_A_UPD;
                    end else if (r_dv && r_cmd == CMD_FREE) begin
                        if (rdata.start + rdata.len == r_h) begin
                            r_hl   <= 1'b1;
                            r_li   <= r_didx;
                            r_lst  <= rdata.start;
                            r_llen <= rdata.len;
                        end
                        if (rdata.start == r_h + r_span) begin
                            r_hr   <= 1'b1;
                            r_ri   <= r_didx;
                            r_rlen <= rdata.len;
                        end
                    end else if (!r_dv && !issue) begin
                        if (r_cmd == CMD_ALLOC) begin
                            r_status <= ST_NOFIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_F_UPD;
                        end
                    end
                end
                S_A_UPD: begin
                    r_granted <= OFS_W'(r_fst + DW'(HDR_BYTES));
                    r_free    <= r_free - OFS_W'(r_need);
                    r_live    <= r_live + 1'b1;
                    if (newlen == '0) begin
                        r_rd_cnt <= CNT_W'(r_fidx) + 1'b1;
                        r_state  <= S_DN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_F_UPD: begin
                    if (!r_hl && !r_hr && r_count >= CNT_W'(MAX_EXTENTS)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_free <= r_free + OFS_W'(r_span);
                        if (r_live != '0) begin
                            r_live <= r_live - 1'b1;
                        end
                        if (r_hl && hr_eff) begin
                            r_rd_cnt <= CNT_W'(r_ri) + 1'b1;
                            r_state  <= S_DN;
                        end else if (r_hl || r_hr) begin
                            r_state <= S_DONE;
                        end else begin
                            r_rd_cnt <= r_count;
                            r_state  <= S_UP;
                        end
                    end
                end
                S_DN: begin
                    if (issue) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end else if (!r_dv) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_UP: begin
                    if (issue) begin
                        r_rd_cnt <= cnt_m1;
                    end else if (!r_dv) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_rsp_valid || i_rsp_ready) begin
                        r_rsp.status         <= r_status;
                        r_rsp.granted_offset <= r_granted;
                        r_rsp.free_bytes     <= r_free;
                        r_rsp.live_blocks    <= r_live[LIV_W-1:0];
                        r_rsp.free_entries   <= ENT_W'(r_count);
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp       = r_rsp;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_EXTENTS)) else $error("extent count overflow");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready) else $error("back-to-back accept");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_dv) else $error("stray table read in idle");
endmodule
`default_nettype wire

>>> bench/tb_first_fit_heap_allocator_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_heap_allocator_top;
    import ffha_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_req i_req = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    always #5 i_clk = ~i_clk;

    first_fit_heap_allocator_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    // allocator state mirror
    logic [31:0] ext_start [MAX_EXTENTS];
    logic [31:0] ext_len   [MAX_EXTENTS];
    int unsigned ext_cnt;
    logic [15:0] hdr_size  [HEAP_BYTES];
    int unsigned live_cnt;
    logic [31:0] free_sum;
    int unsigned granted_list[$];

    t_rsp rsp_queue[$];
    int   err_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;
    int   accepted_req = 0;

    function automatic void heap_reset();
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            ext_start[k] = 0;
            ext_len[k] = 0;
        end
        ext_len[0] = HEAP_BYTES;
        ext_cnt = 1;
        live_cnt = 0;
        free_sum = HEAP_BYTES;
    endfunction

    function automatic void drop_extent(int unsigned k);
        for (int unsigned j = k; j + 1 < ext_cnt; j++) begin
            ext_start[j] = ext_start[j+1];
            ext_len[j] = ext_len[j+1];
        end
        ext_cnt--;
    endfunction

    function automatic t_rsp heap_step(t_req r);
        t_rsp        res;
        logic [31:0] need, h, span;
        bit          has_l, has_r, done;
        int unsigned li, ri;
        res = '0;
        res.status = ST_OK;
        li = 0;
        ri = 0;
        has_l = 0;
        has_r = 0;
        done = 0;
        if (r.command == CMD_ALLOC) begin
            need = r.request_bytes + HDR_BYTES;
            res.status = ST_NOFIT;
            for (int unsigned k = 0; k < ext_cnt && !done; k++) begin
                if (ext_len[k] >= need) begin
                    h = ext_start[k];
                    if (h < HEAP_BYTES) hdr_size[h] = 16'(r.request_bytes);
                    res.granted_offset = OFS_W'(h + HDR_BYTES);
                    granted_list.push_back(h + HDR_BYTES);
                    ext_start[k] = h + need;
                    ext_len[k] = ext_len[k] - need;
                    if (ext_len[k] == 0) drop_extent(k);
                    free_sum = free_sum - need;
                    live_cnt++;
                    res.status = ST_OK;
                    done = 1;
                end
            end
        end else if (r.release_offset >= HDR_BYTES &&
                     r.release_offset - HDR_BYTES < HEAP_BYTES) begin
            h = r.release_offset - HDR_BYTES;
            span = hdr_size[h] + HDR_BYTES;
            for (int unsigned k = 0; k < ext_cnt; k++) begin
                if (ext_start[k] + ext_len[k] == h) begin has_l = 1; li = k; end
                if (ext_start[k] == h + span) begin has_r = 1; ri = k; end
            end
            if (has_l && has_r && li == ri) has_r = 0;
            if (has_l && has_r) begin
                ext_len[li] = ext_len[li] + ext_len[ri] + span;
                drop_extent(ri);
            end else if (has_l) begin
                ext_len[li] = ext_len[li] + span;
            end else if (has_r) begin
                ext_start[ri] = h;
                ext_len[ri] = ext_len[ri] + span;
            end else if (ext_cnt >= MAX_EXTENTS) begin
                res.status = ST_FULL;
                done = 1;
            end else begin
                for (int unsigned j = ext_cnt; j > 0; j--) begin
                    ext_start[j] = ext_start[j-1];
                    ext_len[j] = ext_len[j-1];
                end
                ext_start[0] = h;
                ext_len[0] = span;
                ext_cnt++;
            end
            if (!done) begin
                free_sum = free_sum + span;
                if (live_cnt > 0) live_cnt--;
            end
        end
        res.free_bytes = free_sum[OFS_W-1:0];
        res.live_blocks = live_cnt[LIV_W-1:0];
        res.free_entries = ext_cnt[ENT_W-1:0];
        return res;
    endfunction

    task automatic send_request(t_req r);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        rsp_queue.push_back(heap_step(r));
    endtask

    function automatic t_req mk_alloc(int unsigned n);
        t_req r;
        r.command = CMD_ALLOC;
        r.request_bytes = REQ_W'(n);
        r.release_offset = OFS_W'($urandom);
        return r;
    endfunction

    function automatic t_req mk_free(int unsigned ofs);
        t_req r;
        r.command = CMD_FREE;
        r.request_bytes = REQ_W'($urandom);
        r.release_offset = OFS_W'(ofs);
        return r;
    endfunction

    // pick a previously granted offset so the header is written (offset 0 if none)
    function automatic t_req rand_free();
        int unsigned idx;
        if (granted_list.size() == 0) return mk_free(0);
        idx = $urandom_range(granted_list.size() - 1);
        if ($urandom_range(9) == 0) return mk_free(granted_list[idx]);
        begin
            int unsigned ofs;
            ofs = granted_list[idx];
            granted_list.delete(idx);
            return mk_free(ofs);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_rsp);
                    err_cnt++;
                end else begin
                    t_rsp e;
                    e = rsp_queue.pop_front();
                    if (o_rsp.status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status,
                                 o_rsp.status);
                        err_cnt++;
                    end
                    if (o_rsp.granted_offset !== e.granted_offset) begin
                        $display("%0t: granted_offset exp %0d got %0d", $time,
                                 e.granted_offset, o_rsp.granted_offset);
                        err_cnt++;
                    end
                    if (o_rsp.free_bytes !== e.free_bytes) begin
                        $display("%0t: free_bytes exp %0d got %0d", $time,
                                 e.free_bytes, o_rsp.free_bytes);
                        err_cnt++;
                    end
                    if (o_rsp.live_blocks !== e.live_blocks) begin
                        $display("%0t: live_blocks exp %0d got %0d", $time,
                                 e.live_blocks, o_rsp.live_blocks);
                        err_cnt++;
                    end
                    if (o_rsp.free_entries !== e.free_entries) begin
                        $display("%0t: free_entries exp %0d got %0d", $time,
                                 e.free_entries, o_rsp.free_entries);
                        err_cnt++;
                    end
                end
            end
            i_rsp_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    typedef struct {
        t_req r;
        bit   chk;
        t_rsp e;
    } t_row;

    t_row dir_rows[$];

    function automatic void add_row(t_req r, bit chk, t_rsp e);
        t_row w;
        w.r = r;
        w.chk = chk;
        w.e = e;
        dir_rows.push_back(w);
    endfunction

    function automatic t_rsp rsp(logic [1:0] s, int g, int fb, int lb, int fe);
        t_rsp x;
        x.status = s;
        x.granted_offset = OFS_W'(g);
        x.free_bytes = OFS_W'(fb);
        x.live_blocks = LIV_W'(lb);
        x.free_entries = ENT_W'(fe);
        return x;
    endfunction

    task automatic run_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            t_req r;
            int unsigned sel;
            sel = $urandom_range(99);
            if (sel < 3) r = mk_free($urandom);
            else if (sel < 6) r = mk_alloc($urandom_range(4095));
            else if (sel < 50 && granted_list.size() > 0) r = rand_free();
            else if ($urandom_range(9) == 0) r = mk_alloc($urandom_range(4088));
            else r = mk_alloc($urandom_range(40));
            // avoid freeing a never-written header
            if (r.command == CMD_FREE && r.release_offset >= HDR_BYTES &&
                r.release_offset - HDR_BYTES < HEAP_BYTES &&
                hdr_size[r.release_offset - HDR_BYTES] === 16'hxxxx)
                r.release_offset = 0;
            send_request(r);
        end
    endtask

    initial begin
        t_rsp e;
        heap_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_rsp_ready <= 1'b1;
        @(posedge i_clk);

        add_row(mk_free(0), 1, rsp(ST_OK, 0, 4096, 0, 1));
        add_row(mk_free(4104), 1, rsp(ST_OK, 0, 4096, 0, 1));
        add_row(mk_free(8191), 1, rsp(ST_OK, 0, 4096, 0, 1));
        add_row(mk_alloc(4089), 1, rsp(ST_NOFIT, 0, 4096, 0, 1));
        add_row(mk_alloc(4095), 1, rsp(ST_NOFIT, 0, 4096, 0, 1));
        add_row(mk_alloc(0), 1, rsp(ST_OK, 8, 4088, 1, 1));
        add_row(mk_alloc(8), 1, rsp(ST_OK, 16, 4072, 2, 1));
        add_row(mk_alloc(16), 1, rsp(ST_OK, 32, 4048, 3, 1));
        add_row(mk_free(16), 0, e);
        add_row(mk_free(8), 0, e);
        add_row(mk_free(32), 0, e);
        add_row(mk_free(8), 0, e);
        add_row(mk_free(8), 0, e);
        add_row(mk_alloc(4088), 0, e);
        add_row(mk_alloc(0), 0, e);
        add_row(mk_free(8), 0, e);
        add_row(mk_alloc(4000), 0, e);
        add_row(mk_alloc(80), 0, e);
        add_row(mk_free(16), 0, e);
        add_row(mk_free(8), 0, e);
        add_row(mk_free(8), 0, e);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].r);
            if (dir_rows[i].chk && rsp_queue[$] !== dir_rows[i].e) begin
                $display("%0t: table row %0d exp %p got %p", $time, i,
                         dir_rows[i].e, rsp_queue[$]);
                err_cnt++;
            end
        end
        i_req_valid <= 1'b0;
        while (rsp_queue.size() != 0) @(posedge i_clk);

        // fill the table with eight-byte holes to reach the full case
        for (int i = 0; i < 2 * MAX_EXTENTS + 4; i++) send_request(mk_alloc(0));
        for (int i = 0; i < 2 * MAX_EXTENTS + 4; i += 2) begin
            if (granted_list.size() > i) send_request(mk_free(granted_list[i]));
        end
        granted_list.delete();

        run_phase(180, 0, 0);
        run_phase(160, 84, 0);
        run_phase(160, 0, 84);
        run_phase(180, 25, 25);
        i_req_valid <= 1'b0;

        recv_stall_pct = 0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && rsp_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> first_fit_heap_allocator_top.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/first_fit_heap_allocator_top.sv
bench/tb_first_fit_heap_allocator_top.sv
